### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the group_quantized_matvec design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

### design/gqmv_pkg.sv
// ----------------------------------------------------------------------------
// gqmv_pkg
// types and constants of the group quantized matrix-vector unit
// ----------------------------------------------------------------------------
package gqmv_pkg;

    // sizing, group size and lane count are powers of two
    localparam int MAX_LENGTH       = 4096;
    localparam int GROUP_SIZE       = 64;
    localparam int LANES            = 8;

    localparam int TOKEN_DEPTH      = MAX_LENGTH / LANES;
    localparam int SCALE_DEPTH      = MAX_LENGTH / GROUP_SIZE;
    localparam int CHUNKS_PER_GROUP = GROUP_SIZE / LANES;
    localparam int GROUP_LOG2       = $clog2(GROUP_SIZE);

    localparam int POS_W  = $clog2(TOKEN_DEPTH);
    localparam int GRP_W  = (SCALE_DEPTH > 1) ? $clog2(SCALE_DEPTH) : 1;
    localparam int SUB_W  = (CHUNKS_PER_GROUP > 1) ? $clog2(CHUNKS_PER_GROUP) : 1;
    localparam int GCNT_W = $clog2(SCALE_DEPTH + 1);

    // field widths
    localparam int VLEN_W    = 13;
    localparam int RCNT_W    = 15;
    localparam int ROW_W     = 14;
    localparam int MAX_ROWS  = 16384;
    localparam int LANES_W   = 64;
    localparam int SCALE_W   = 32;
    localparam int SUM_W     = 64;
    localparam int BYTE_W    = 8;

    // arithmetic widths
    localparam int PROD_W = 2 * BYTE_W;
    localparam int DOT_W  = PROD_W + $clog2(GROUP_SIZE);
    localparam int MAC_W  = DOT_W + SCALE_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RCNT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VECTOR_LENGTH = 1'b0,
        CFG_ROW_COUNT     = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_WEIGHT = 1'b1
    } t_cmd;

    // control that travels with a weight chunk down the pipeline
    typedef struct packed {
        logic             close;
        logic             row_end;
        logic [ROW_W-1:0] row_index;
        logic             last_row;
    } t_ctl;

    typedef struct packed {
        logic signed [SUM_W-1:0] row_sum;
        logic [ROW_W-1:0]        row_index;
        logic                    last_row;
    } t_out_item;

endpackage

### design/gqmv_in_if.sv
// ----------------------------------------------------------------------------
// gqmv_in_if
// input channel: token loads and weight chunks
// ----------------------------------------------------------------------------
interface gqmv_in_if import gqmv_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [LANES_W-1:0] lanes;
    logic [SCALE_W-1:0] group_scale;

    modport source (output valid, output cmd, output lanes, output group_scale,
                    input ready);
    modport sink   (input valid, input cmd, input lanes, input group_scale,
                    output ready);

endinterface

### design/gqmv_out_if.sv
// ----------------------------------------------------------------------------
// gqmv_out_if
// output channel: one scaled sum per finished row
// ----------------------------------------------------------------------------
interface gqmv_out_if import gqmv_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_W-1:0]        row_index;
    logic                    last_row;

    modport source (output valid, output row_sum, output row_index, output last_row,
                    input ready);
    modport sink   (input valid, input row_sum, input row_index, input last_row,
                    output ready);

endinterface

### design/group_quantized_matvec.sv
// ----------------------------------------------------------------------------
// group_quantized_matvec
// int8 group quantized matrix-vector product with q0.32 scaling
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless stalled, token loads and weight
// chunks alike. A weight chunk goes through eight int8 lanes and an adder
// tree, the group's token and weight scales meet in a 32x32 multiplier, and
// the group dot product is scaled in a second multiplier before the saturating
// row accumulator, past registered input, lane, dot and product stages. Results
// wait in a two-entry output queue, and the input stalls only while two row
// results are in flight or waiting. Token and token scale memories need no
// clearing after reset; configuration writes belong between matrices.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module group_quantized_matvec import gqmv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gqmv_in_if.sink               i_in,
    gqmv_out_if.source            o_out
);

    localparam int VLC_W = $clog2(MAX_LENGTH + 1);

    // configuration
    logic [VLEN_W-1:0] r_vlen;
    logic [RCNT_W-1:0] r_rcnt;

    // positions and per-row state
    logic [POS_W-1:0]   r_lpos, r_wpos;
    logic [SUB_W-1:0]   r_lsub, r_wsub;
    logic [GRP_W-1:0]   r_lgrp, r_wgrp;
    logic [SCALE_W-1:0] r_hold;
    logic [ROW_W-1:0]   r_row;

    // pipeline
    logic                      r_v1, r_v2, r_v3, r_v4;
    t_ctl                      r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [LANES_W-1:0]        r1_lanes;
    logic [SCALE_W-1:0]        r1_hold;
    logic [SCALE_W-1:0]        r2_scale, r3_scale;
    logic signed [MAC_W-1:0]   r4_mac;
    logic signed [SUM_W-1:0]   r_acc;

    // output queue
    t_out_item  r_oq0, r_oq1;
    logic [1:0] r_ocnt;
    logic [1:0] r_cred;

    logic [VLC_W-1:0]          w_vlc;
    logic [VLC_W-1:0]          w_graw;
    logic [GCNT_W-1:0]         w_groups;
    logic [RCNT_W-1:0]         w_rows;
    logic                      w_last;
    logic                      w_in_acc, w_lacc, w_wacc;
    logic                      w_lend, w_wend, w_close;
    logic [SCALE_W-1:0]        w_hold_eff;
    logic [LANES_W-1:0]        w_tok_rd;
    logic [SCALE_W-1:0]        w_ts_rd;
    logic signed [PROD_W-1:0]  w_prod [LANES];
    logic signed [DOT_W-1:0]   w_dot;
    logic [2*SCALE_W-1:0]      n_sprod;
    logic signed [MAC_W-1:0]   n_mac;
    logic signed [SUM_W:0]     w_wide;
    logic signed [SUM_W-1:0]   w_sat;
    logic signed [SUM_W-1:0]   n_acc;
    logic                      w_push, w_pop, w_cinc;
    t_out_item                 w_new;

    // effective length in groups and rows
    always_comb begin
        w_vlc    = (r_vlen > MAX_LENGTH) ? VLC_W'(MAX_LENGTH) : VLC_W'(r_vlen);
        w_graw   = w_vlc >> GROUP_LOG2;
        w_groups = (w_graw == '0) ? GCNT_W'(1) : GCNT_W'(w_graw);
        if (r_rcnt == '0) begin
            w_rows = RCNT_W'(1);
        end else if (r_rcnt > MAX_ROWS) begin
            w_rows = RCNT_W'(MAX_ROWS);
        end else begin
            w_rows = r_rcnt;
        end
        w_last = (RCNT_W'(r_row) + RCNT_W'(1)) >= w_rows;
    end

    // position decode
    always_comb begin
        w_lend = (GCNT_W'(r_lgrp) >= w_groups)
              || ((GCNT_W'(r_lgrp) + GCNT_W'(1) == w_groups)
                  && (r_lsub == SUB_W'(CHUNKS_PER_GROUP - 1)));
        w_wend = (GCNT_W'(r_wgrp) >= w_groups)
              || ((GCNT_W'(r_wgrp) + GCNT_W'(1) == w_groups)
                  && (r_wsub == SUB_W'(CHUNKS_PER_GROUP - 1)));
        w_close    = w_wend || (r_wsub == SUB_W'(CHUNKS_PER_GROUP - 1));
        w_hold_eff = (r_wsub == '0) ? i_in.group_scale : r_hold;
    end

    assign i_in.ready = (r_cred < 2'd2);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_lacc     = w_in_acc && (i_in.cmd == CMD_LOAD);
    assign w_wacc     = w_in_acc && (i_in.cmd == CMD_WEIGHT);
    assign w_cinc     = w_wacc && w_wend;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= VLEN_W'(4096);
            r_rcnt <= RCNT_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VECTOR_LENGTH: r_vlen <= i_cfg_data[VLEN_W-1:0];
                CFG_ROW_COUNT:     r_rcnt <= i_cfg_data[RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // token load position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpos <= '0;
            r_lsub <= '0;
            r_lgrp <= '0;
        end else if (w_lacc) begin
            if (w_lend) begin
                r_lpos <= '0;
                r_lsub <= '0;
                r_lgrp <= '0;
            end else begin
                r_lpos <= r_lpos + POS_W'(1);
                if (r_lsub == SUB_W'(CHUNKS_PER_GROUP - 1)) begin
                    r_lsub <= '0;
                    r_lgrp <= r_lgrp + GRP_W'(1);
                end else begin
                    r_lsub <= r_lsub + SUB_W'(1);
                end
            end
        end
    end

    // weight position, scale hold and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_wsub <= '0;
            r_wgrp <= '0;
            r_hold <= '0;
            r_row  <= '0;
        end else if (w_wacc) begin
            r_hold <= w_hold_eff;
            if (w_wend) begin
                r_wpos <= '0;
                r_wsub <= '0;
                r_wgrp <= '0;
                r_row  <= w_last ? '0 : r_row + ROW_W'(1);
            end else begin
                r_wpos <= r_wpos + POS_W'(1);
                if (r_wsub == SUB_W'(CHUNKS_PER_GROUP - 1)) begin
                    r_wsub <= '0;
                    r_wgrp <= r_wgrp + GRP_W'(1);
                end else begin
                    r_wsub <= r_wsub + SUB_W'(1);
                end
            end
        end
    end

    gqmv_ram #(
        .WIDTH (LANES_W),
        .DEPTH (TOKEN_DEPTH)
    ) u_token_ram (
        .i_clk   (i_clk),
        .i_we    (w_lacc),
        .i_waddr (r_lpos),
        .i_wdata (i_in.lanes),
        .i_raddr (r_wpos),
        .o_rdata (w_tok_rd)
    );

    gqmv_ram #(
        .WIDTH (SCALE_W),
        .DEPTH (SCALE_DEPTH)
    ) u_scale_ram (
        .i_clk   (i_clk),
        .i_we    (w_lacc && (r_lsub == '0)),
        .i_waddr (r_lgrp),
        .i_wdata (i_in.group_scale),
        .i_raddr (r_wgrp),
        .o_rdata (w_ts_rd)
    );

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_wacc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign n_sprod = {{SCALE_W{1'b0}}, w_ts_rd} * {{SCALE_W{1'b0}}, r1_hold};
    assign n_mac   = w_dot * $signed({1'b0, r3_scale});

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_ctl1.close     <= w_close;
        r_ctl1.row_end   <= w_wend;
        r_ctl1.row_index <= r_row;
        r_ctl1.last_row  <= w_last;
        r1_lanes         <= i_in.lanes;
        r1_hold          <= w_hold_eff;
        r_ctl2           <= r_ctl1;
        r2_scale         <= n_sprod[2*SCALE_W-1:SCALE_W];
        r_ctl3           <= r_ctl2;
        r3_scale         <= r2_scale;
        r_ctl4           <= r_ctl3;
        r4_mac           <= n_mac;
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        gqmv_lane u_lane (
            .i_clk     (i_clk),
            .i_weight  (r1_lanes[k*BYTE_W +: BYTE_W]),
            .i_token   (w_tok_rd[k*BYTE_W +: BYTE_W]),
            .o_product (w_prod[k])
        );
    end

    gqmv_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .i_close    (r_ctl2.close),
        .i_products (w_prod),
        .o_dot      (w_dot)
    );

    // saturating row accumulator
    always_comb begin
        w_wide = {r_acc[SUM_W-1], r_acc} + (SUM_W + 1)'(r4_mac);
        if (w_wide[SUM_W] != w_wide[SUM_W-1]) begin
            w_sat = w_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sat = w_wide[SUM_W-1:0];
        end
        n_acc = r_ctl4.close ? w_sat : r_acc;
    end

    assign w_push          = r_v4 && r_ctl4.row_end;
    assign w_pop           = o_out.valid && o_out.ready;
    assign w_new.row_sum   = n_acc;
    assign w_new.row_index = r_ctl4.row_index;
    assign w_new.last_row  = r_ctl4.last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_v4) begin
            r_acc <= r_ctl4.row_end ? '0 : n_acc;
        end
    end

    // two-entry output queue, head in r_oq0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
            r_cred <= '0;
        end else begin
            r_cred <= r_cred + 2'(w_cinc) - 2'(w_pop);
            if (w_push && !w_pop) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && !w_pop) begin
            if (r_ocnt == 2'd0) begin
                r_oq0 <= w_new;
            end else begin
                r_oq1 <= w_new;
            end
        end else if (w_pop && !w_push) begin
            r_oq0 <= r_oq1;
        end else if (w_pop && w_push) begin
            if (r_ocnt == 2'd1) begin
                r_oq0 <= w_new;
            end else begin
                r_oq0 <= r_oq1;
                r_oq1 <= w_new;
            end
        end
    end

    assign o_out.valid     = (r_ocnt != 2'd0);
    assign o_out.row_sum   = r_oq0.row_sum;
    assign o_out.row_index = r_oq0.row_index;
    assign o_out.last_row  = r_oq0.last_row;

    `ASSERT_NEVER(a_cred_max, i_clk, i_rst_n, r_cred > 2'd2)
    `ASSERT_NEVER(a_queue_le_cred, i_clk, i_rst_n, r_ocnt > r_cred)
    `ASSERT_IMPLIES(a_row_end_closes, i_clk, i_rst_n, r_v4 && r_ctl4.row_end, r_ctl4.close)
    `ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, w_push, r_ocnt < 2'd2 || w_pop)

endmodule

### design/gqmv_ram.sv
// ----------------------------------------------------------------------------
// gqmv_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gqmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/gqmv_lane.sv
// ----------------------------------------------------------------------------
// gqmv_lane
// one lane: signed int8 weight times signed int8 token, registered
// ----------------------------------------------------------------------------
module gqmv_lane import gqmv_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [BYTE_W-1:0] i_weight,
    input  logic signed [BYTE_W-1:0] i_token,
    output logic signed [PROD_W-1:0] o_product
);

    logic signed [PROD_W-1:0] r_product;

    always_ff @(posedge i_clk) begin
        r_product <= i_weight * i_token;
    end

    assign o_product = r_product;

endmodule

### design/gqmv_merge.sv
// ----------------------------------------------------------------------------
// gqmv_merge
// sums the lane products and keeps the running dot product of the group
// ----------------------------------------------------------------------------
module gqmv_merge import gqmv_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_close,
    input  logic signed [PROD_W-1:0] i_products [LANES],
    output logic signed [DOT_W-1:0]  o_dot
);

    logic signed [DOT_W-1:0] w_sum;
    logic signed [DOT_W-1:0] n_dot;
    logic signed [DOT_W-1:0] r_dot;
    logic signed [DOT_W-1:0] r_out;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            w_sum = w_sum + DOT_W'(i_products[k]);
        end
        n_dot = r_dot + w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
        end else if (i_valid) begin
            r_dot <= i_close ? '0 : n_dot;
        end
    end

    // running group dot product, registered; complete at group close, scaled by the next stage
    always_ff @(posedge i_clk) begin
        r_out <= n_dot;
    end

    assign o_dot = r_out;

endmodule

### tb/gqmv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqmv_checker
// Watches the configuration port and both channels of the matrix-vector unit,
// keeps its own copy of the token memories, positions and row accumulator,
// predicts each row sum and compares every returned row field by field.
// ----------------------------------------------------------------------------
module gqmv_checker import gqmv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gqmv_in_if                    i_in,
    gqmv_out_if                   i_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [LANES_W-1:0]      token_mem [TOKEN_DEPTH];
    logic [SCALE_W-1:0]      token_scale_mem [SCALE_DEPTH];
    int unsigned             load_pos;
    int unsigned             weight_pos;
    int                      group_dot_sum;
    logic [SCALE_W-1:0]      weight_scale;
    logic signed [SUM_W-1:0] row_acc;
    logic [ROW_W-1:0]        row_ctr;
    logic [VLEN_W-1:0]       vlen;
    logic [RCNT_W-1:0]       rcnt;
    t_out_item               row_sums_due [$];
    int                      fails = 0;
    int                      due_count = 0;

    assign o_fail_count = fails;
    assign o_pending    = due_count;

    function automatic int unsigned active_chunks(logic [VLEN_W-1:0] len);
        int unsigned n;
        n = len;
        if (n > MAX_LENGTH) n = MAX_LENGTH;
        n = (n / GROUP_SIZE) * GROUP_SIZE;
        if (n < GROUP_SIZE) n = GROUP_SIZE;
        return n / LANES;
    endfunction

    function automatic int unsigned active_rows(logic [RCNT_W-1:0] cnt);
        int unsigned r;
        r = cnt;
        if (r < 1) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r;
    endfunction

    function automatic int lane_dot(logic [LANES_W-1:0] w, logic [LANES_W-1:0] t);
        int acc;
        acc = 0;
        for (int k = 0; k < LANES; k++) begin
            acc += int'(signed'(w[BYTE_W*k +: BYTE_W])) * int'(signed'(t[BYTE_W*k +: BYTE_W]));
        end
        return acc;
    endfunction

    function automatic logic signed [SUM_W-1:0] add_saturated(logic signed [SUM_W-1:0] a,
                                                              logic signed [SUM_W-1:0] b);
        logic [SUM_W:0] wide;
        wide = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (wide[SUM_W] != wide[SUM_W-1]) begin
            return wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return wide[SUM_W-1:0];
    endfunction

    task automatic predict_row_sum(input t_cmd cmd, input logic [LANES_W-1:0] lanes,
                                   input logic [SCALE_W-1:0] scale);
        int unsigned        pos;
        int unsigned        chunks;
        logic               row_end;
        logic               is_last;
        logic [63:0]        scale_prod;
        logic [SCALE_W-1:0] q_scale;
        t_out_item          res;
        chunks = active_chunks(vlen);
        if (cmd == CMD_LOAD) begin
            pos = (load_pos >= TOKEN_DEPTH) ? 0 : load_pos;
            token_mem[pos] = lanes;
            if (pos % CHUNKS_PER_GROUP == 0) begin
                token_scale_mem[(pos / CHUNKS_PER_GROUP) % SCALE_DEPTH] = scale;
            end
            load_pos = (pos + 1 >= chunks) ? 0 : pos + 1;
        end else begin
            pos = (weight_pos >= TOKEN_DEPTH) ? 0 : weight_pos;
            if (pos % CHUNKS_PER_GROUP == 0) weight_scale = scale;
            group_dot_sum += lane_dot(lanes, token_mem[pos]);
            row_end = (pos + 1 >= chunks);
            // group close: scale product cut to q0.32, then into the row sum
            if (row_end || pos % CHUNKS_PER_GROUP == CHUNKS_PER_GROUP - 1) begin
                scale_prod = 64'(token_scale_mem[(pos / CHUNKS_PER_GROUP) % SCALE_DEPTH])
                           * 64'(weight_scale);
                q_scale = scale_prod[63:32];
                row_acc = add_saturated(row_acc,
                                        longint'(group_dot_sum) * longint'({32'b0, q_scale}));
                group_dot_sum = 0;
            end
            if (!row_end) begin
                weight_pos = pos + 1;
            end else begin
                is_last = (int'(row_ctr) + 1 >= active_rows(rcnt));
                res.row_sum   = row_acc;
                res.row_index = row_ctr;
                res.last_row  = is_last;
                row_sums_due.push_back(res);
                row_acc    = '0;
                weight_pos = 0;
                row_ctr    = is_last ? '0 : row_ctr + 1'b1;
            end
        end
    endtask

    task automatic check_row_sum();
        t_out_item exp_row;
        if (row_sums_due.size() == 0) begin
            fails++;
            $error("row transaction with no row pending: row_index %0d", i_out.row_index);
        end else begin
            exp_row = row_sums_due.pop_front();
            if (exp_row.row_sum !== i_out.row_sum) begin
                fails++;
                $error("row_sum expected %0d got %0d", exp_row.row_sum, i_out.row_sum);
            end
            if (exp_row.row_index !== i_out.row_index) begin
                fails++;
                $error("row_index expected %0d got %0d", exp_row.row_index, i_out.row_index);
            end
            if (exp_row.last_row !== i_out.last_row) begin
                fails++;
                $error("last_row expected %0d got %0d", exp_row.last_row, i_out.last_row);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_pos      = 0;
            weight_pos    = 0;
            group_dot_sum = 0;
            weight_scale  = '0;
            row_acc       = '0;
            row_ctr       = '0;
            vlen          = VLEN_W'(MAX_LENGTH);
            rcnt          = RCNT_W'(4096);
            row_sums_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_VECTOR_LENGTH) begin
                    vlen = i_cfg_data[VLEN_W-1:0];
                end else begin
                    rcnt = i_cfg_data[RCNT_W-1:0];
                end
            end
            if (i_out.valid && i_out.ready) check_row_sum();
            if (i_in.valid && i_in.ready) begin
                predict_row_sum(t_cmd'(i_in.cmd), i_in.lanes, i_in.group_scale);
            end
        end
        due_count = row_sums_due.size();
    end

endmodule

### tb/tb_group_quantized_matvec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_quantized_matvec
// Drives token loads and weight rows into the matrix-vector unit with random
// gaps and output stalls, across several vector lengths and row counts, and
// lets the checker judge every row result.
// ----------------------------------------------------------------------------
module tb_group_quantized_matvec;
    import gqmv_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int BIG_PHASE    = 2;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int unsigned cur_chunks = TOKEN_DEPTH;
    int unsigned ld_pos     = 0;
    int unsigned wt_pos     = 0;
    bit          written [TOKEN_DEPTH];
    bit          steady     = 1'b0;

    gqmv_in_if  in_ch ();
    gqmv_out_if out_ch ();

    group_quantized_matvec u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    gqmv_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int unsigned active_chunks(logic [VLEN_W-1:0] len);
        int unsigned n;
        n = len;
        if (n > MAX_LENGTH) n = MAX_LENGTH;
        n = (n / GROUP_SIZE) * GROUP_SIZE;
        if (n < GROUP_SIZE) n = GROUP_SIZE;
        return n / LANES;
    endfunction

    function automatic logic [LANES_W-1:0] random_lanes();
        logic [LANES_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = {LANES{8'h80}};
            1: v = {LANES{8'h7f}};
            2: v = {LANES{8'hff}};
            3: v = '0;
            4: begin
                for (int k = 0; k < LANES; k++) begin
                    v[BYTE_W*k +: BYTE_W] = ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7f;
                end
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [SCALE_W-1:0] random_scale();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'h0100_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == CFG_VECTOR_LENGTH) cur_chunks = active_chunks(data[VLEN_W-1:0]);
    endtask

    task automatic send_item(input t_cmd cmd, input logic [LANES_W-1:0] lanes,
                             input logic [SCALE_W-1:0] scale);
        int          gap;
        int unsigned pos;
        gap = pick_gap();
        if (gap > 0) begin
            if (in_ch.valid) in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.lanes       <= lanes;
        in_ch.group_scale <= scale;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        // positions as the block sees them, to keep reads on loaded tokens
        if (cmd == CMD_LOAD) begin
            pos = (ld_pos >= TOKEN_DEPTH) ? 0 : ld_pos;
            written[pos] = 1'b1;
            ld_pos = (pos + 1 >= cur_chunks) ? 0 : pos + 1;
        end else begin
            pos = (wt_pos >= TOKEN_DEPTH) ? 0 : wt_pos;
            wt_pos = (pos + 1 >= cur_chunks) ? 0 : pos + 1;
        end
        @(negedge clk);
    endtask

    task automatic send_traffic_item();
        bit want_load;
        if (ld_pos != 0) want_load = ($urandom_range(0, 9) != 0);
        else want_load = ($urandom_range(0, 99) < 12);
        if (!want_load && !written[wt_pos]) want_load = 1'b1;
        send_item(want_load ? CMD_LOAD : CMD_WEIGHT, random_lanes(), random_scale());
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int r;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end else if (r < 20) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, (r < 30) ? 80 : 8)) @(negedge clk);
        end
    end

    initial begin
        int          n_random;
        int          phase;
        int          budget;
        int unsigned vlen_val;
        int unsigned rows_val;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = 1'b0;
        in_ch.lanes       = '0;
        in_ch.group_scale = '0;
        out_ch.ready      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // one group per row, largest magnitudes at full scale
        write_reg(CFG_VECTOR_LENGTH, CFG_DATA_W'(GROUP_SIZE));
        for (int k = 0; k < CHUNKS_PER_GROUP; k++) begin
            send_item(CMD_LOAD, {LANES{8'h80}}, (k == 0) ? 32'hffff_ffff : $urandom);
        end
        for (int k = 0; k < CHUNKS_PER_GROUP; k++) begin
            send_item(CMD_WEIGHT, {LANES{8'h80}}, (k == 0) ? 32'hffff_ffff : $urandom);
        end
        for (int k = 0; k < CHUNKS_PER_GROUP; k++) begin
            send_item(CMD_WEIGHT, {LANES{8'h7f}}, (k == 0) ? 32'hffff_ffff : $urandom);
        end

        n_random = 0;
        phase    = 0;
        while (n_random < RANDOM_ITEMS) begin
            settle();
            if (phase == BIG_PHASE) begin
                case ($urandom_range(0, 2))
                    0: vlen_val = MAX_LENGTH;
                    1: vlen_val = 8191;
                    default: vlen_val = 15'h7fff;
                endcase
                write_reg(CFG_VECTOR_LENGTH, CFG_DATA_W'(vlen_val));
                write_reg(CFG_ROW_COUNT, CFG_DATA_W'(1));
                budget = 2 * TOKEN_DEPTH + $urandom_range(0, 60);
                n_random += budget;
            end else begin
                if ($urandom_range(0, 4) != 0) begin
                    case ($urandom_range(0, 9))
                        0: vlen_val = 0;
                        1: vlen_val = $urandom_range(1, 400);
                        2: vlen_val = GROUP_SIZE;
                        default: vlen_val = GROUP_SIZE * $urandom_range(1, 4);
                    endcase
                    // bits above the register width are dropped by the block
                    if ($urandom_range(0, 3) == 0) vlen_val |= 32'h6000;
                    write_reg(CFG_VECTOR_LENGTH, CFG_DATA_W'(vlen_val));
                end
                if ($urandom_range(0, 4) != 0) begin
                    case ($urandom_range(0, 9))
                        0: rows_val = 1;
                        1: rows_val = MAX_ROWS;
                        2: rows_val = 0;
                        3: rows_val = 15'h7fff;
                        4: rows_val = $urandom_range(0, 32767);
                        default: rows_val = $urandom_range(2, 6);
                    endcase
                    write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows_val));
                end
                budget = $urandom_range(60, 200);
                n_random += budget;
            end
            steady = ($urandom_range(0, 3) == 0);
            repeat (budget) send_traffic_item();
            // next weight chunk must read a loaded token, whatever length comes next
            while (!written[wt_pos]) send_item(CMD_LOAD, random_lanes(), random_scale());
            phase++;
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
